// ----- hdl/frt_pkg.sv -----
// ----------------------------------------------------------------------------
// Fragment reassembly tracker package
// Shared constants, result codes and the request record that passes from the
// front end to the back end of the tracker.
// ----------------------------------------------------------------------------
package frt_pkg;

    localparam int SLOTS_DEF        = 8;
    localparam int LEN_BITS_DEF     = 24;
    localparam int HEADER_BYTES_DEF = 16;
    localparam int COOKIE_BYTES     = 8;

    // Depth of the request queue between the front and back ends.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    localparam logic [2:0] ST_SINGLE   = 3'd0;
    localparam logic [2:0] ST_PARTIAL  = 3'd1;
    localparam logic [2:0] ST_COMPLETE = 3'd2;
    localparam logic [2:0] ST_SHORT    = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    localparam logic [1:0] KIND_SHORT  = 2'd0;
    localparam logic [1:0] KIND_SINGLE = 2'd1;
    localparam logic [1:0] KIND_FRAG   = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] plen;
        logic [63:0] frag_cookie;
        logic [30:0] sender_process;
        logic [30:0] sender_socket;
        logic [23:0] announced_len;
    } frt_req_t;

endpackage

// ----- hdl/frt_front.sv -----
// ----------------------------------------------------------------------------
// Fragment reassembly tracker front end
// Accepts datagram headers, classifies them as short, single or fragment,
// works out the payload length and queues the request for the back end.
// ----------------------------------------------------------------------------
module frt_front
    import frt_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] datagram_len,
    input  logic [63:0] frag_cookie,
    input  logic [30:0] sender_process,
    input  logic [30:0] sender_socket,
    input  logic [23:0] announced_len,
    output logic        q_valid,
    output frt_req_t    q_req,
    input  logic        q_pop
);

    localparam logic [15:0] COOKIE_LEN = 16'(COOKIE_BYTES);
    localparam logic [15:0] FRAG_MIN   = 16'(COOKIE_BYTES + HEADER_BYTES);

    frt_req_t           q_mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    frt_req_t           req_new;
    logic               push;

    always_comb
    begin
        req_new.frag_cookie    = frag_cookie;
        req_new.sender_process = sender_process;
        req_new.sender_socket  = sender_socket;
        req_new.announced_len  = announced_len;
        if (datagram_len < COOKIE_LEN)
        begin
            req_new.kind = KIND_SHORT;
            req_new.plen = '0;
        end
        else if (frag_cookie == 64'd0)
        begin
            req_new.kind = KIND_SINGLE;
            req_new.plen = datagram_len - COOKIE_LEN;
        end
        else if (datagram_len < FRAG_MIN)
        begin
            req_new.kind = KIND_SHORT;
            req_new.plen = '0;
        end
        else
        begin
            req_new.kind = KIND_FRAG;
            req_new.plen = datagram_len - FRAG_MIN;
        end
    end

    assign in_ready = (count_reg != QCNT_W'(QDEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign q_req    = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= req_new;
        end
    end

endmodule

// ----- hdl/frt_back.sv -----
// ----------------------------------------------------------------------------
// Fragment reassembly tracker back end
// Holds the per-sender message table, looks up the sender of each fragment,
// updates the slot and drives the registered result.
// ----------------------------------------------------------------------------
module frt_back
    import frt_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int LEN_BITS = LEN_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  frt_req_t    q_req,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [2:0]  slot_index,
    output logic [23:0] write_offset,
    output logic [15:0] payload_len,
    output logic [23:0] message_len,
    output logic        replaced_stale
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW     = (LEN_BITS > 16) ? LEN_BITS : 16;

    localparam logic B_IDLE = 1'b0;
    localparam logic B_DONE = 1'b1;

    logic state_reg, state_next;

    logic [SLOTS-1:0]    entry_valid_reg;
    logic [30:0]         entry_process_reg  [SLOTS];
    logic [30:0]         entry_socket_reg   [SLOTS];
    logic [63:0]         entry_cookie_reg   [SLOTS];
    logic [LEN_BITS-1:0] entry_total_reg    [SLOTS];
    logic [LEN_BITS-1:0] entry_received_reg [SLOTS];

    frt_req_t         work_reg;
    logic [SLOTS-1:0] match_reg, match_next;
    logic [SLOTS-1:0] same_reg, same_next;
    logic [SLOTS-1:0] free_reg;

    logic               out_valid_reg, out_valid_next;
    logic [2:0]         status_reg;
    logic [2:0]         slot_index_reg;
    logic [23:0]        write_offset_reg;
    logic [15:0]        payload_len_reg;
    logic [23:0]        message_len_reg;
    logic               replaced_stale_reg;

    logic [SLOT_W-1:0]   hit_idx, free_idx, slot;
    logic                hit, same, free_any, fresh;
    logic [LEN_BITS-1:0] ann, tot, rcv, space, rcv_new, rcv_upd;
    logic                ovf, done_msg, advance, tbl_write;
    logic [2:0]          res_status;
    logic [2:0]          res_slot;
    logic [23:0]         res_off;
    logic [23:0]         res_mlen;
    logic                res_stale;

    // Lookup stage: compare the queue head against every slot at once.
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            match_next[i] = entry_valid_reg[i]
                && (entry_process_reg[i] == q_req.sender_process)
                && (entry_socket_reg[i] == q_req.sender_socket);
            same_next[i]  = match_next[i] && (entry_cookie_reg[i] == q_req.frag_cookie);
        end
    end

    // Lowest matching slot and lowest free slot.
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                hit_idx = SLOT_W'(i);
            end
            if (free_reg[i])
            begin
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        hit      = |match_reg;
        same     = |same_reg;
        free_any = |free_reg;
        slot     = hit ? hit_idx : free_idx;
        // A new or restarted message starts from the announced length.
        fresh    = !(hit && same);
        ann      = LEN_BITS'(work_reg.announced_len);
        tot      = fresh ? ann : entry_total_reg[slot];
        rcv      = fresh ? '0 : entry_received_reg[slot];
        space    = tot - rcv;
        ovf      = CW'(work_reg.plen) > CW'(space);
        rcv_new  = rcv + LEN_BITS'(work_reg.plen);
        done_msg = !ovf && !(rcv_new < tot);
        rcv_upd  = ovf ? rcv : rcv_new;

        res_status = ST_SHORT;
        res_slot   = '0;
        res_off    = '0;
        res_mlen   = '0;
        res_stale  = 1'b0;
        tbl_write  = 1'b0;
        case (work_reg.kind)
            KIND_SINGLE:
            begin
                res_status = ST_SINGLE;
                res_mlen   = 24'(work_reg.plen);
            end
            KIND_FRAG:
            begin
                if (!hit && !free_any)
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    tbl_write = 1'b1;
                    res_slot  = 3'(slot);
                    res_off   = 24'(rcv);
                    res_stale = hit && !same;
                    if (ovf)
                    begin
                        res_status = ST_OVERFLOW;
                    end
                    else if (!done_msg)
                    begin
                        res_status = ST_PARTIAL;
                    end
                    else
                    begin
                        res_status = ST_COMPLETE;
                        res_mlen   = 24'(tot);
                    end
                end
            end
            default:
            begin
                res_status = ST_SHORT;
            end
        endcase
    end

    assign q_pop   = (state_reg == B_IDLE) && q_valid;
    assign advance = (state_reg == B_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (advance)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= B_IDLE;
            out_valid_reg   <= 1'b0;
            entry_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (advance && tbl_write)
            begin
                entry_valid_reg[slot] <= !done_msg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            work_reg  <= q_req;
            match_reg <= match_next;
            same_reg  <= same_next;
            free_reg  <= ~entry_valid_reg;
        end
        if (advance && tbl_write)
        begin
            entry_process_reg[slot]  <= work_reg.sender_process;
            entry_socket_reg[slot]   <= work_reg.sender_socket;
            entry_cookie_reg[slot]   <= work_reg.frag_cookie;
            entry_total_reg[slot]    <= tot;
            entry_received_reg[slot] <= rcv_upd;
        end
        if (advance)
        begin
            status_reg         <= res_status;
            slot_index_reg     <= res_slot;
            write_offset_reg   <= res_off;
            payload_len_reg    <= (work_reg.kind == KIND_SHORT) ? 16'd0 : work_reg.plen;
            message_len_reg    <= res_mlen;
            replaced_stale_reg <= res_stale;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign slot_index     = slot_index_reg;
    assign write_offset   = write_offset_reg;
    assign payload_len    = payload_len_reg;
    assign message_len    = message_len_reg;
    assign replaced_stale = replaced_stale_reg;

endmodule

// ----- hdl/fragment_reassembly_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// Fragment reassembly tracker
// Tracks in-progress fragmented messages, one table slot per sender, and
// reports for each received datagram header where its payload belongs.
//
//   Channel  Direction  Handshake             Payload
//   in       request    in_valid / in_ready   datagram_len .. announced_len
//   out      result     out_valid / out_ready status .. replaced_stale
//
// In the back end the idle state compares the sender against all slots, and
// the done state selects the slot, updates it and loads the result; no new
// request is taken until the result of the last one has been loaded.
// A two-entry queue lets the front accept while the back end or the result
// register is stalled. Reset clears all slots at once; no sweep is needed.
// ----------------------------------------------------------------------------
module fragment_reassembly_tracker_unit
    import frt_pkg::*;
#(
    parameter int SLOTS        = SLOTS_DEF,
    parameter int LEN_BITS     = LEN_BITS_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] datagram_len,
    input  logic [63:0] frag_cookie,
    input  logic [30:0] sender_process,
    input  logic [30:0] sender_socket,
    input  logic [23:0] announced_len,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [2:0]  slot_index,
    output logic [23:0] write_offset,
    output logic [15:0] payload_len,
    output logic [23:0] message_len,
    output logic        replaced_stale
);

    logic     q_valid;
    logic     q_pop;
    frt_req_t q_req;

    frt_front #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .datagram_len   (datagram_len),
        .frag_cookie    (frag_cookie),
        .sender_process (sender_process),
        .sender_socket  (sender_socket),
        .announced_len  (announced_len),
        .q_valid        (q_valid),
        .q_req          (q_req),
        .q_pop          (q_pop)
    );

    frt_back #(
        .SLOTS    (SLOTS),
        .LEN_BITS (LEN_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_req          (q_req),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .slot_index     (slot_index),
        .write_offset   (write_offset),
        .payload_len    (payload_len),
        .message_len    (message_len),
        .replaced_stale (replaced_stale)
    );

endmodule

// ----- hdl/frt_checker.sv -----
// ----------------------------------------------------------------------------
// Fragment reassembly tracker checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module frt_checker
    import frt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [15:0] datagram_len,
    input logic [63:0] frag_cookie,
    input logic [30:0] sender_process,
    input logic [30:0] sender_socket,
    input logic [23:0] announced_len,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [2:0]  slot_index,
    input logic [23:0] write_offset,
    input logic [15:0] payload_len,
    input logic [23:0] message_len,
    input logic        replaced_stale
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(slot_index) && $stable(write_offset) && $stable(message_len))
        else $error("result changed while stalled");

    // A single-datagram message is delivered whole, outside the table.
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_SINGLE) |-> (slot_index == 3'd0)
            && (write_offset == 24'd0) && (message_len == 24'(payload_len))
            && !replaced_stale)
        else $error("bad single delivery result");

    // A short drop carries no other information.
    a_short: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_SHORT) |-> (payload_len == 16'd0)
            && (message_len == 24'd0) && (slot_index == 3'd0)
            && (write_offset == 24'd0) && !replaced_stale)
        else $error("bad short drop result");

    // Only a delivery reports a message length.
    a_no_mlen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_PARTIAL || status == ST_OVERFLOW
            || status == ST_FULL) |-> (message_len == 24'd0))
        else $error("message length reported without delivery");

    // A completed message ends at its reported length.
    a_complete: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_COMPLETE)
            |-> (25'(write_offset) + 25'(payload_len) == 25'(message_len))
            || (message_len[23:16] != 8'd0) || (write_offset[23:16] != 8'd0))
        else $error("completion length mismatch");

endmodule

bind fragment_reassembly_tracker_unit frt_checker u_frt_checker (.*);

// ----- tb/frt_result_checker.sv -----
// ----------------------------------------------------------------------------
// Fragment reassembly tracker result checker
// Watches both channels of the tracker. For every accepted request it runs its
// own copy of the slot table to predict the result, queues it, and compares
// each accepted result field by field against the oldest queued prediction.
// ----------------------------------------------------------------------------
module frt_result_checker
    import frt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [15:0] datagram_len,
    input  logic [63:0] frag_cookie,
    input  logic [30:0] sender_process,
    input  logic [30:0] sender_socket,
    input  logic [23:0] announced_len,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  status,
    input  logic [2:0]  slot_index,
    input  logic [23:0] write_offset,
    input  logic [15:0] payload_len,
    input  logic [23:0] message_len,
    input  logic        replaced_stale,
    output int          fail_count,
    output int          pending,
    output int          results_checked,
    output int          completions,
    output int          stale_restarts,
    output int          full_drops,
    output int          overflow_drops
);

    localparam int NSLOTS     = SLOTS_DEF;
    localparam int FRAG_BYTES = COOKIE_BYTES + HEADER_BYTES_DEF;
    localparam int MAX_PRINTS = 40;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  slot;
        logic [23:0] offs;
        logic [15:0] plen;
        logic [23:0] mlen;
        logic        stale;
    } frag_result_t;

    // Shadow copy of the reassembly table.
    logic        slot_busy     [NSLOTS];
    logic [30:0] slot_process  [NSLOTS];
    logic [30:0] slot_socket   [NSLOTS];
    logic [63:0] slot_cookie   [NSLOTS];
    logic [23:0] slot_total    [NSLOTS];
    logic [23:0] slot_received [NSLOTS];

    frag_result_t expected_results[$];
    frag_result_t predicted;
    frag_result_t observed;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fail_count < MAX_PRINTS)
            $display("%0t: MISMATCH %s: got %0h, expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    // Works out the tracker's answer to one datagram header and updates the
    // shadow table the same way the block must.
    task automatic track_datagram(input logic [15:0] dlen, input logic [63:0] cookie,
                                  input logic [30:0] proc, input logic [30:0] sock,
                                  input logic [23:0] ann, output frag_result_t r);
        int          hit;
        logic [15:0] plen;
        logic [23:0] offs;
        logic [23:0] space;
        logic        stale;
        r     = '0;
        hit   = -1;
        stale = 1'b0;
        if (dlen < COOKIE_BYTES) begin
            r.status = ST_SHORT;
            return;
        end
        if (cookie == 64'd0) begin
            r.status = ST_SINGLE;
            r.plen   = dlen - 16'(COOKIE_BYTES);
            r.mlen   = 24'(r.plen);
            return;
        end
        if (dlen < FRAG_BYTES) begin
            r.status = ST_SHORT;
            return;
        end
        plen = dlen - 16'(FRAG_BYTES);

        for (int i = 0; i < NSLOTS; i++)
            if (hit < 0 && slot_busy[i] && slot_process[i] == proc && slot_socket[i] == sock)
                hit = i;

        if (hit >= 0 && slot_cookie[hit] != cookie) begin
            stale          = 1'b1;
            slot_busy[hit] = 1'b0;
        end else if (hit < 0) begin
            for (int i = 0; i < NSLOTS; i++)
                if (hit < 0 && !slot_busy[i])
                    hit = i;
            if (hit < 0) begin
                r.status = ST_FULL;
                r.plen   = plen;
                return;
            end
        end

        if (!slot_busy[hit]) begin
            slot_busy[hit]     = 1'b1;
            slot_process[hit]  = proc;
            slot_socket[hit]   = sock;
            slot_cookie[hit]   = cookie;
            slot_total[hit]    = ann;
            slot_received[hit] = '0;
        end

        offs    = slot_received[hit];
        space   = slot_total[hit] - offs;
        r.slot  = 3'(hit);
        r.offs  = offs;
        r.plen  = plen;
        r.stale = stale;
        if (24'(plen) > space) begin
            r.status = ST_OVERFLOW;
            return;
        end
        slot_received[hit] = offs + 24'(plen);
        if (slot_received[hit] < slot_total[hit]) begin
            r.status = ST_PARTIAL;
        end else begin
            slot_busy[hit] = 1'b0;
            r.status       = ST_COMPLETE;
            r.mlen         = slot_total[hit];
        end
    endtask

    initial begin
        fail_count      = 0;
        pending         = 0;
        results_checked = 0;
        completions     = 0;
        stale_restarts  = 0;
        full_drops      = 0;
        overflow_drops  = 0;
        for (int i = 0; i < NSLOTS; i++)
            slot_busy[i] = 1'b0;
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            for (int i = 0; i < NSLOTS; i++)
                slot_busy[i] = 1'b0;
            expected_results.delete();
        end else begin
            // Results first: a request accepted in this cycle cannot have
            // its result on the output yet.
            if (out_valid && out_ready) begin
                observed = {status, slot_index, write_offset, payload_len, message_len,
                            replaced_stale};
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no request outstanding", 64'(observed), 0);
                end else begin
                    predicted = expected_results.pop_front();
                    results_checked++;
                    if (observed.status !== predicted.status)
                        report_mismatch("status", 64'(observed.status), 64'(predicted.status));
                    if (observed.slot !== predicted.slot)
                        report_mismatch("slot_index", 64'(observed.slot), 64'(predicted.slot));
                    if (observed.offs !== predicted.offs)
                        report_mismatch("write_offset", 64'(observed.offs), 64'(predicted.offs));
                    if (observed.plen !== predicted.plen)
                        report_mismatch("payload_len", 64'(observed.plen), 64'(predicted.plen));
                    if (observed.mlen !== predicted.mlen)
                        report_mismatch("message_len", 64'(observed.mlen), 64'(predicted.mlen));
                    if (observed.stale !== predicted.stale)
                        report_mismatch("replaced_stale", 64'(observed.stale),
                                        64'(predicted.stale));
                    if (predicted.status == ST_COMPLETE) completions++;
                    if (predicted.status == ST_FULL) full_drops++;
                    if (predicted.status == ST_OVERFLOW) overflow_drops++;
                    if (predicted.stale) stale_restarts++;
                end
            end
            if (in_valid && in_ready) begin
                track_datagram(datagram_len, frag_cookie, sender_process, sender_socket,
                               announced_len, predicted);
                expected_results.push_back(predicted);
            end
        end
        pending = expected_results.size();
    end

endmodule

// ----- tb/tb_fragment_reassembly_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// Fragment reassembly tracker testbench
// Drives datagram headers into the tracker: a directed opening that covers the
// length limits, single deliveries, completion, overflow, stale restart and a
// full table, then interleaved fragmented messages from a pool of senders
// mixed with malformed traffic. Both channels stall at random; a checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_fragment_reassembly_tracker_unit;
    import frt_pkg::*;

    localparam int POOL           = 10;
    localparam int MAX_CHUNK      = 65535 - COOKIE_BYTES - HEADER_BYTES_DEF;
    localparam int RANDOM_ITEMS   = 1430;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 20;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] datagram_len;
    logic [63:0] frag_cookie;
    logic [30:0] sender_process;
    logic [30:0] sender_socket;
    logic [23:0] announced_len;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [2:0]  slot_index;
    logic [23:0] write_offset;
    logic [15:0] payload_len;
    logic [23:0] message_len;
    logic        replaced_stale;

    int fail_count;
    int pending;
    int results_checked;
    int completions;
    int stale_restarts;
    int full_drops;
    int overflow_drops;

    int   requests_sent;
    int   stall_count;
    int   hold_token;
    logic quiet_mode;

    // Senders with the message each one is currently sending.
    logic [30:0] pool_process [POOL];
    logic [30:0] pool_socket  [POOL];
    logic [63:0] pool_cookie  [POOL];
    logic        pool_open    [POOL];
    int          pool_total   [POOL];
    int          pool_sent    [POOL];

    fragment_reassembly_tracker_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .datagram_len   (datagram_len),
        .frag_cookie    (frag_cookie),
        .sender_process (sender_process),
        .sender_socket  (sender_socket),
        .announced_len  (announced_len),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .slot_index     (slot_index),
        .write_offset   (write_offset),
        .payload_len    (payload_len),
        .message_len    (message_len),
        .replaced_stale (replaced_stale)
    );

    frt_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .datagram_len    (datagram_len),
        .frag_cookie     (frag_cookie),
        .sender_process  (sender_process),
        .sender_socket   (sender_socket),
        .announced_len   (announced_len),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .slot_index      (slot_index),
        .write_offset    (write_offset),
        .payload_len     (payload_len),
        .message_len     (message_len),
        .replaced_stale  (replaced_stale),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .completions     (completions),
        .stale_restarts  (stale_restarts),
        .full_drops      (full_drops),
        .overflow_drops  (overflow_drops)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [63:0] random_cookie();
        logic [63:0] c;
        c = {$urandom, $urandom};
        if (c == 64'd0)
            c = 64'd1;
        return c;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic offer_datagram(input logic [15:0] dlen, input logic [63:0] cookie,
                                  input logic [30:0] proc, input logic [30:0] sock,
                                  input logic [23:0] ann);
        if (!quiet_mode) begin
            while ($urandom_range(99) < 8) begin
                in_valid = 1'b0;
                @(negedge clk);
            end
        end
        in_valid       = 1'b1;
        datagram_len   = dlen;
        frag_cookie    = cookie;
        sender_process = proc;
        sender_socket  = sock;
        announced_len  = ann;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        requests_sent++;
    endtask

    task automatic start_message(input int p, input logic [63:0] cookie, input int total);
        pool_cookie[p] = cookie;
        pool_total[p]  = total;
        pool_sent[p]   = 0;
        pool_open[p]   = 1'b1;
    endtask

    task automatic send_piece(input int p, input int chunk);
        offer_datagram(16'(chunk + COOKIE_BYTES + HEADER_BYTES_DEF), pool_cookie[p],
                       pool_process[p], pool_socket[p], 24'(pool_total[p]));
        if (chunk <= pool_total[p] - pool_sent[p]) begin
            pool_sent[p] += chunk;
            if (pool_sent[p] == pool_total[p])
                pool_open[p] = 1'b0;
        end
    endtask

    task automatic drain_results();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic random_datagram();
        int p;
        int pick;
        int remaining;
        int cap;
        int chunk;
        int total;
        pick = $urandom_range(99);
        p    = $urandom_range(POOL - 1);
        if (pick < 72) begin
            if (!pool_open[p] || $urandom_range(99) < 12) begin
                total = $urandom_range(99);
                if (total < 80)
                    total = $urandom_range(300);
                else if (total < 95)
                    total = $urandom_range(2 * MAX_CHUNK);
                else
                    total = $urandom_range(24'hFFFFFF);
                start_message(p, random_cookie(), total);
            end
            remaining = pool_total[p] - pool_sent[p];
            cap       = (remaining < MAX_CHUNK) ? remaining : MAX_CHUNK;
            if ($urandom_range(99) < 10 && remaining <= MAX_CHUNK - 16)
                chunk = remaining + 1 + $urandom_range(15);
            else if ($urandom_range(99) < 45)
                chunk = cap;
            else
                chunk = $urandom_range(cap);
            send_piece(p, chunk);
        end else if (pick < 78) begin
            offer_datagram(16'($urandom_range(COOKIE_BYTES - 1)), {$urandom, $urandom},
                           pool_process[p], pool_socket[p], 24'($urandom));
        end else if (pick < 84) begin
            offer_datagram(16'($urandom_range(COOKIE_BYTES + HEADER_BYTES_DEF - 1,
                                              COOKIE_BYTES)),
                           random_cookie(), pool_process[p], pool_socket[p], 24'($urandom));
        end else if (pick < 92) begin
            offer_datagram(16'($urandom_range(65535, COOKIE_BYTES)), 64'd0,
                           31'($urandom), 31'($urandom), 24'($urandom));
        end else begin
            offer_datagram(16'($urandom), {$urandom, $urandom}, pool_process[p],
                           pool_socket[p], 24'($urandom));
        end
    endtask

    // The receiver; a bump of hold_token makes it refuse results for a while.
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready = 1'b0;
            end else if (quiet_mode) begin
                out_ready = 1'b1;
            end else begin
                out_ready = ($urandom_range(99) >= 8);
            end
        end
    end

    initial begin
        stall_count = 0;
        while (stall_count < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready)))
                stall_count++;
            else
                stall_count = 0;
        end
        $display("Watchdog: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        logic [30:0] id_a;
        logic [30:0] id_b;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        datagram_len   = '0;
        frag_cookie    = '0;
        sender_process = '0;
        sender_socket  = '0;
        announced_len  = '0;
        quiet_mode     = 1'b0;
        hold_token     = 0;
        requests_sent  = 0;

        // Extremes, a shared process id with different sockets, swapped ids.
        id_a            = 31'($urandom);
        id_b            = 31'($urandom);
        pool_process[0] = '0;
        pool_socket[0]  = '0;
        pool_process[1] = '1;
        pool_socket[1]  = '1;
        pool_process[2] = id_a;
        pool_socket[2]  = id_b;
        pool_process[3] = id_a;
        pool_socket[3]  = id_b ^ 31'd1;
        pool_process[4] = id_b;
        pool_socket[4]  = id_a;
        for (int i = 0; i < POOL; i++) begin
            if (i >= 5) begin
                pool_process[i] = 31'($urandom);
                pool_socket[i]  = 31'($urandom);
            end
            pool_open[i]  = 1'b0;
            pool_total[i] = 0;
            pool_sent[i]  = 0;
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Too short for a cookie, single deliveries at both length limits,
        // and a fragment too short for its header.
        offer_datagram(16'd0, 64'd0, '0, '0, '0);
        offer_datagram(16'd7, '1, '1, '1, '1);
        offer_datagram(16'd8, 64'd0, '0, '0, '0);
        offer_datagram(16'hFFFF, 64'd0, '1, '1, '1);
        offer_datagram(16'(COOKIE_BYTES + HEADER_BYTES_DEF - 1), 64'd1, '0, '0, '0);

        // Zero announced length with an empty payload completes at once.
        start_message(0, 64'd1, 0);
        send_piece(0, 0);
        // Partial, overflow that leaves the entry alone, then completion.
        start_message(0, '1, 30);
        send_piece(0, 10);
        send_piece(0, 30);
        send_piece(0, 20);
        // Same sender with a new cookie discards the old message.
        start_message(1, random_cookie(), 100);
        send_piece(1, 40);
        start_message(1, random_cookie(), 50);
        send_piece(1, 5);
        // Fill the remaining slots, one of them with the largest message,
        // then one more sender finds the table full.
        for (int p = 2; p <= 8; p++) begin
            start_message(p, random_cookie(), (p == 2) ? 24'hFFFFFF : 1000);
            send_piece(p, (p == 2) ? MAX_CHUNK : 1);
        end
        start_message(9, random_cookie(), 10);
        send_piece(9, 3);
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 200)
                hold_token++;
            if (n == 400)
                quiet_mode = 1'b1;
            if (n == 700)
                quiet_mode = 1'b0;
            if (n == 900)
                drain_results();
            random_datagram();
        end
        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Sent %0d datagram headers; %0d results checked.",
                 requests_sent, results_checked);
        $display("Seen %0d completions, %0d stale restarts, %0d overflows, %0d full-table drops.",
                 completions, stale_restarts, overflow_drops, full_drops);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
